// ===== src/nbgv_pkg.sv =====
// Package for the gravity velocity step core: item types, codes and widths.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
package nbgv_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [23:0]        other_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               saturated;
  } out_item_t;

  localparam logic [1:0] MODE_ACC = 2'd0;
  localparam logic [1:0] MODE_ADV = 2'd1;
  localparam logic [1:0] MODE_LDP = 2'd2;
  localparam logic [1:0] MODE_LDV = 2'd3;

  localparam logic [1:0] CFG_GRAV = 2'd0;
  localparam logic [1:0] CFG_STEP = 2'd1;
  localparam logic [1:0] CFG_MASS = 2'd2;

  localparam logic [2:0] K_GRAV = 3'd0;
  localparam logic [2:0] K_ADV  = 3'd1;
  localparam logic [2:0] K_LDP  = 3'd2;
  localparam logic [2:0] K_LDV  = 3'd3;
  localparam logic [2:0] K_HOLD = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    in_item_t   item;
  } q_entry_t;

  localparam int MUL_AW = 49;
  localparam int MUL_BW = 64;
  localparam int MUL_PW = 98;
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 64;

endpackage

// ===== src/nbgv_front.sv =====
// Front end: accepts input items, tags each with the work it needs and
// holds them in a two-entry queue for the back end. Depends on nbgv_pkg.
`timescale 1ns / 1ps
module nbgv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nbgv_pkg::in_item_t in_item,
  input  logic [23:0]       own_mass,
  output logic              q_valid,
  input  logic              q_ready,
  output nbgv_pkg::q_entry_t q_entry
);
  import nbgv_pkg::*;

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  q_entry_t   entry;
  logic       push;
  logic       pop;

  always_comb begin
    entry.item = in_item;
    case (in_item.mode)
      MODE_ACC: entry.kind = (own_mass == 24'd0) ? K_HOLD : K_GRAV;
      MODE_ADV: entry.kind = K_ADV;
      MODE_LDP: entry.kind = K_LDP;
      default:  entry.kind = K_LDV;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_entry  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/nbgv_mul.sv =====
// Iterative multiplier: 49-bit operand times 64-bit operand, 16 bits a cycle.
// Depends on nbgv_pkg.
`timescale 1ns / 1ps
module nbgv_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [nbgv_pkg::MUL_AW-1:0] a,
  input  logic [nbgv_pkg::MUL_BW-1:0] b,
  output logic                        done,
  output logic [nbgv_pkg::MUL_PW-1:0] prod
);
  import nbgv_pkg::*;

  logic [MUL_AW-1:0] a_reg;
  logic [MUL_BW-1:0] b_reg;
  logic [1:0]        cnt;
  logic              busy;
  logic [MUL_AW+15:0] part;

  assign part = a_reg * b_reg[MUL_BW-1 -: 16];

  always_ff @(posedge clk) begin
    if (go) begin
      a_reg <= a;
      b_reg <= b;
      prod  <= '0;
    end else if (busy) begin
      b_reg <= b_reg << 16;
      prod  <= (prod << 16) + MUL_PW'(part);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/nbgv_div.sv =====
// Restoring divider: 49-bit dividend by 64-bit divisor, one quotient bit a cycle.
// Depends on nbgv_pkg.
`timescale 1ns / 1ps
module nbgv_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [nbgv_pkg::DIV_NW-1:0] dividend,
  input  logic [nbgv_pkg::DIV_DW-1:0] divisor,
  output logic                        done,
  output logic [nbgv_pkg::DIV_NW-1:0] quot
);
  import nbgv_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [5:0]        cnt;
  logic              busy;
  logic [DIV_DW:0]   trial;
  logic              ge;

  assign trial = {rem, quot[DIV_NW-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? DIV_DW'(trial - {1'b0, dvs}) : DIV_DW'(trial);
      quot <= {quot[DIV_NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/nbgv_back.sv =====
// Back end: sequencer holding position and velocity, with an iterative square
// root and the shared multiplier and divider. Depends on nbgv_pkg, nbgv_mul, nbgv_div.
`timescale 1ns / 1ps
module nbgv_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  nbgv_pkg::q_entry_t q_entry,
  input  logic [31:0]        grav_constant,
  input  logic [31:0]        time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output nbgv_pkg::out_item_t out_item
);
  import nbgv_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQRT = 4'd2;
  localparam logic [3:0] S_INV  = 4'd3;
  localparam logic [3:0] S_G0   = 4'd4;
  localparam logic [3:0] S_G1   = 4'd5;
  localparam logic [3:0] S_G2   = 4'd6;
  localparam logic [3:0] S_DIR  = 4'd7;
  localparam logic [3:0] S_C    = 4'd8;
  localparam logic [3:0] S_ADV  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic [MUL_PW-1:0] CAP = MUL_PW'(1) << 48;

  logic [3:0]         state;
  logic [1:0]         idx;
  logic signed [31:0] vel [3];
  logic signed [31:0] pos [3];
  logic [32:0]        ad [3];
  logic               neg [3];
  logic               k;
  logic [23:0]        m_other;
  logic [63:0]        s;
  logic [32:0]        r;
  logic [48:0]        inv;
  logic [48:0]        g;
  logic [48:0]        dir;
  logic               flag;
  logic [63:0]        sq_n;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [4:0]         sq_cnt;
  logic               mul_go;
  logic               div_go;

  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic               mul_done;
  logic [MUL_PW-1:0]  prod;
  logic [DIV_NW-1:0]  div_n;
  logic [DIV_DW-1:0]  div_d;
  logic               div_done;
  logic [DIV_NW-1:0]  quot;

  logic [63:0]        s_sum;
  logic [63:0]        sq_trial;
  logic               sq_ge;
  logic [63:0]        sq_res_next;
  logic signed [32:0] d_in [3];
  logic [31:0]        vel_mag;
  in_item_t           it;

  function automatic logic [48:0] cap_mul(input logic [MUL_PW-1:0] p, input logic sh);
    logic [MUL_PW-1:0] t;
    t = sh ? (p >> 16) : p;
    return (t > CAP) ? CAP[48:0] : t[48:0];
  endfunction

  function automatic logic [32:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -51'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  nbgv_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  nbgv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (quot)
  );

  assign it = q_entry.item;
  assign d_in[0] = {it.vec_x[31], it.vec_x} - {pos[0][31], pos[0]};
  assign d_in[1] = {it.vec_y[31], it.vec_y} - {pos[1][31], pos[1]};
  assign d_in[2] = {it.vec_z[31], it.vec_z} - {pos[2][31], pos[2]};

  assign vel_mag = vel[idx][31] ? 32'(-vel[idx]) : vel[idx];

  assign s_sum       = s + prod[63:0];
  assign sq_trial    = sq_res + sq_bit;
  assign sq_ge       = (sq_n >= sq_trial);
  assign sq_res_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        mul_a = MUL_AW'(ad[idx] >> k);
        mul_b = MUL_BW'(ad[idx] >> k);
      end
      S_G0: begin
        mul_a = MUL_AW'(grav_constant);
        mul_b = MUL_BW'(time_step);
      end
      S_G1: begin
        mul_a = g;
        mul_b = MUL_BW'(m_other);
      end
      S_G2: begin
        mul_a = g;
        mul_b = MUL_BW'(inv);
      end
      S_C: begin
        mul_a = g;
        mul_b = MUL_BW'(dir);
      end
      S_ADV: begin
        mul_a = MUL_AW'(vel_mag);
        mul_b = MUL_BW'(time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (state == S_DIR) begin
      div_n = {ad[idx], 16'd0};
      div_d = DIV_DW'(r);
    end else begin
      div_n = k ? (DIV_NW'(1) << 46) : (DIV_NW'(1) << 48);
      div_d = s;
    end
  end

  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    out_item.vel_x     = vel[0];
    out_item.vel_y     = vel[1];
    out_item.vel_z     = vel[2];
    out_item.pos_x     = pos[0];
    out_item.pos_y     = pos[1];
    out_item.pos_z     = pos[2];
    out_item.saturated = flag;
  end

  always_ff @(posedge clk) begin
    logic [32:0] sv;
    logic [48:0] cv;
    logic [50:0] delta;
    if (rst) begin
      state  <= S_IDLE;
      idx    <= 2'd0;
      mul_go <= 1'b0;
      div_go <= 1'b0;
      flag   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel[i] <= '0;
        pos[i] <= '0;
      end
    end else begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            flag    <= 1'b0;
            idx     <= 2'd0;
            m_other <= it.other_mass;
            case (q_entry.kind)
              K_GRAV: begin
                for (int i = 0; i < 3; i++) begin
                  neg[i] <= d_in[i][32];
                  ad[i]  <= d_in[i][32] ? 33'(-d_in[i]) : 33'(d_in[i]);
                end
                k <= (d_in[0][32] ? (d_in[0] < -33'sd2147483647)
                                  : (d_in[0] > 33'sd2147483647)) ||
                     (d_in[1][32] ? (d_in[1] < -33'sd2147483647)
                                  : (d_in[1] > 33'sd2147483647)) ||
                     (d_in[2][32] ? (d_in[2] < -33'sd2147483647)
                                  : (d_in[2] > 33'sd2147483647));
                s      <= '0;
                mul_go <= 1'b1;
                state  <= S_SQ;
              end
              K_ADV: begin
                mul_go <= 1'b1;
                state  <= S_ADV;
              end
              K_LDP: begin
                pos[0] <= it.vec_x;
                pos[1] <= it.vec_y;
                pos[2] <= it.vec_z;
                state  <= S_OUT;
              end
              K_LDV: begin
                vel[0] <= it.vec_x;
                vel[1] <= it.vec_y;
                vel[2] <= it.vec_z;
                state  <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SQ: begin
          if (mul_done) begin
            s <= s_sum;
            if (idx == 2'd2) begin
              if (s_sum == 64'd0) begin
                state <= S_OUT;
              end else begin
                sq_n   <= s_sum;
                sq_res <= '0;
                sq_bit <= 64'd1 << 62;
                sq_cnt <= 5'd0;
                state  <= S_SQRT;
              end
            end else begin
              idx    <= idx + 2'd1;
              mul_go <= 1'b1;
            end
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_n <= sq_n - sq_trial;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd31) begin
            r      <= {1'b0, sq_res_next[31:0]} << k;
            div_go <= 1'b1;
            state  <= S_INV;
          end
        end
        S_INV: begin
          if (div_done) begin
            inv    <= quot;
            mul_go <= 1'b1;
            state  <= S_G0;
          end
        end
        S_G0: begin
          if (mul_done) begin
            g      <= cap_mul(prod, 1'b1);
            mul_go <= 1'b1;
            state  <= S_G1;
          end
        end
        S_G1: begin
          if (mul_done) begin
            g      <= cap_mul(prod, 1'b0);
            mul_go <= 1'b1;
            state  <= S_G2;
          end
        end
        S_G2: begin
          if (mul_done) begin
            g      <= cap_mul(prod, 1'b1);
            idx    <= 2'd0;
            div_go <= 1'b1;
            state  <= S_DIR;
          end
        end
        S_DIR: begin
          if (div_done) begin
            dir    <= quot;
            mul_go <= 1'b1;
            state  <= S_C;
          end
        end
        S_C: begin
          if (mul_done) begin
            cv       = cap_mul(prod, 1'b1);
            delta    = neg[idx] ? 51'(-{2'b00, cv}) : {2'b00, cv};
            sv       = sat32(51'({{19{vel[idx][31]}}, vel[idx]}) + delta);
            vel[idx] <= sv[31:0];
            if (sv[32]) begin
              flag <= 1'b1;
            end
            if (idx == 2'd2) begin
              state <= S_OUT;
            end else begin
              idx    <= idx + 2'd1;
              div_go <= 1'b1;
              state  <= S_DIR;
            end
          end
        end
        S_ADV: begin
          if (mul_done) begin
            delta    = vel[idx][31] ? 51'(-{4'b0000, prod[62:16]})
                                    : {4'b0000, prod[62:16]};
            sv       = sat32(51'({{19{pos[idx][31]}}, pos[idx]}) + delta);
            pos[idx] <= sv[31:0];
            if (sv[32]) begin
              flag <= 1'b1;
            end
            if (idx == 2'd2) begin
              state <= S_OUT;
            end else begin
              idx    <= idx + 2'd1;
              mul_go <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_SQ || state == S_G0 || state == S_G1 ||
                  state == S_G2 || state == S_C || state == S_ADV))
    else $error("multiplier result arrived outside a multiply step");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_INV || state == S_DIR))
    else $error("divider result arrived outside a divide step");

  a_sqrt_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |=> (state == S_SQRT || state == S_INV))
    else $error("square root left early");

endmodule

// ===== src/nbgv_fifo_top_note.sv =====
// Output holding stage: keeps the last result item for the top level port.
// Depends on nbgv_pkg.
`timescale 1ns / 1ps
module nbgv_fifo_top_note (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nbgv_pkg::out_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output nbgv_pkg::out_item_t out_item
);
  import nbgv_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

endmodule

// ===== src/nbody_gravity_velocity_step_core.sv =====
// Top level of the gravity velocity step core: configuration registers,
// front queue, back sequencer and output register. Depends on nbgv_pkg and all src modules.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_item  (nbgv_pkg::in_item_t)
//   out       output     out_valid / out_ready  out_item (nbgv_pkg::out_item_t)
//   cfg       input      cfg_we                 cfg_index, cfg_data
//
// Load items and accumulate items with zero own mass go straight to the output; advance
// items use the multiplier once per axis; accumulate items run a 32-step square root plus
// four one-bit-a-cycle divisions in the shared divider.
// Reset is synchronous; it clears the state vectors and restores the registers.
// The two-entry input queue keeps taking items while the back end works or a result stalls, until it is full.
`timescale 1ns / 1ps
module nbody_gravity_velocity_step_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nbgv_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output nbgv_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import nbgv_pkg::*;

  logic [31:0] grav_constant;
  logic [31:0] time_step;
  logic [23:0] own_mass;
  logic        q_valid;
  logic        q_ready;
  q_entry_t    q_entry;
  logic        res_valid;
  logic        res_ready;
  out_item_t   res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_constant <= 32'h0001_0000;
      time_step     <= 32'h0001_0000;
      own_mass      <= 24'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAV: grav_constant <= cfg_data;
        CFG_STEP: time_step     <= cfg_data;
        CFG_MASS: own_mass      <= cfg_data[23:0];
        default:  ;
      endcase
    end
  end

  nbgv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .own_mass (own_mass),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  nbgv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_entry       (q_entry),
    .grav_constant (grav_constant),
    .time_step     (time_step),
    .out_valid     (res_valid),
    .out_ready     (res_ready),
    .out_item      (res_item)
  );

  nbgv_fifo_top_note u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_item   (res_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the gravity velocity step core: directed table, directed configuration cases,
// then random items, each result checked against a built-in predictor of velocity and position.
// Depends on nbgv_pkg and nbody_gravity_velocity_step_core.
`timescale 1ns / 1ps
module tb_top;
  import nbgv_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam logic [63:0] FORCE_CAP = 64'd1 << 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_GRAV;
  logic [31:0] cfg_data = '0;

  nbody_gravity_velocity_step_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [31:0] g_const, t_step;
  logic [23:0] m_own;
  logic signed [31:0] body_vel [3];
  logic signed [31:0] body_pos [3];
  out_item_t pending_states[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [63:0] capped_mul(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != 0) return FORCE_CAP;
    p = p >> sh;
    return (p > FORCE_CAP) ? FORCE_CAP : p[63:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t next_body_state(in_item_t it);
    out_item_t r;
    bit flag;
    logic signed [63:0] d [3];
    logic signed [63:0] c;
    logic [63:0] ad [3];
    logic [63:0] e, s, rr, inv, g, dir, st;
    logic signed [31:0] other [3];
    int k;
    flag = 1'b0;
    other[0] = it.vec_x;
    other[1] = it.vec_y;
    other[2] = it.vec_z;
    case (it.mode)
      MODE_ACC: begin
        if (m_own != 0) begin
          k = 0;
          s = 0;
          for (int i = 0; i < 3; i++) begin
            d[i] = 64'(other[i]) - 64'(body_pos[i]);
            ad[i] = d[i] < 0 ? -d[i] : d[i];
            if (ad[i] >= 64'd1 << 31) k = 1;
          end
          for (int i = 0; i < 3; i++) begin
            e = ad[i] >> k;
            s = s + e * e;
          end
          if (s != 0) begin
            rr = root_floor(s) << k;
            inv = (64'd1 << (48 - 2 * k)) / s;
            g = capped_mul(g_const, t_step, 16);
            g = capped_mul(g, 64'(it.other_mass), 0);
            g = capped_mul(g, inv, 16);
            for (int i = 0; i < 3; i++) begin
              dir = (ad[i] << 16) / rr;
              c = capped_mul(g, dir, 16);
              if (d[i] < 0) c = -c;
              body_vel[i] = clip32(64'(body_vel[i]) + c, flag);
            end
          end
        end
      end
      MODE_ADV: begin
        for (int i = 0; i < 3; i++) begin
          st = ((body_vel[i] < 0 ? -64'(body_vel[i]) : 64'(body_vel[i])) * 64'(t_step)) >> 16;
          c = body_vel[i] < 0 ? -$signed(st) : $signed(st);
          body_pos[i] = clip32(64'(body_pos[i]) + c, flag);
        end
      end
      MODE_LDP: for (int i = 0; i < 3; i++) body_pos[i] = other[i];
      default: for (int i = 0; i < 3; i++) body_vel[i] = other[i];
    endcase
    r.vel_x = body_vel[0];
    r.vel_y = body_vel[1];
    r.vel_z = body_vel[2];
    r.pos_x = body_pos[0];
    r.pos_y = body_pos[1];
    r.pos_z = body_pos[2];
    r.saturated = flag;
    return r;
  endfunction

  task automatic note_mismatch(string what, out_item_t exp_r, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", what, exp_r, got);
  endtask

  // Output side: random stalls plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_states.size() == 0) begin
        note_mismatch("unexpected item", '0, out_item);
      end else begin
        out_item_t exp_r;
        exp_r = pending_states.pop_front();
        if (out_item.vel_x !== exp_r.vel_x || out_item.vel_y !== exp_r.vel_y ||
            out_item.vel_z !== exp_r.vel_z || out_item.pos_x !== exp_r.pos_x ||
            out_item.pos_y !== exp_r.pos_y || out_item.pos_z !== exp_r.pos_z ||
            out_item.saturated !== exp_r.saturated)
          note_mismatch("field", exp_r, out_item);
      end
    end
    if (hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 9) < 7) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 30) == 0) ? 1'b1 : 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // The valid line stays high between back-to-back items; a gap drops it first.
  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 60);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_states.push_back(next_body_state(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRAV: g_const = val;
      CFG_STEP: t_step = val;
      CFG_MASS: m_own = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int span);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  typedef struct {
    in_item_t it;
    bit typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{'{MODE_ADV, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 1'b0}},
    '{'{MODE_ACC, 0, 0, 0, 24'hffffff}, 1'b1, '{0, 0, 0, 0, 0, 0, 1'b0}},
    '{'{MODE_LDV, 32'sh7fffffff, 32'sh80000000, 32'sh10000, 0}, 1'b1,
      '{32'sh7fffffff, 32'sh80000000, 32'sh10000, 0, 0, 0, 1'b0}},
    '{'{MODE_ADV, 0, 0, 0, 0}, 1'b1,
      '{32'sh7fffffff, 32'sh80000000, 32'sh10000,
        32'sh7fffffff, 32'sh80000000, 32'sh10000, 1'b0}},
    '{'{MODE_ADV, 0, 0, 0, 0}, 1'b1,
      '{32'sh7fffffff, 32'sh80000000, 32'sh10000,
        32'sh7fffffff, 32'sh80000000, 32'sh20000, 1'b1}},
    '{'{MODE_LDP, 32'sh7fffffff, 32'sh80000000, 32'sh20000, 0}, 1'b0, '{default: 0}},
    '{'{MODE_ACC, 32'sh7fffffff, 32'sh80000000, 32'sh20000, 24'd5}, 1'b0, '{default: 0}},
    '{'{MODE_LDP, 0, 0, 0, 0}, 1'b0, '{default: 0}},
    '{'{MODE_LDV, 0, 0, 0, 0}, 1'b0, '{default: 0}},
    '{'{MODE_ACC, 32'sh10000, 0, 0, 24'd1}, 1'b0, '{default: 0}},
    '{'{MODE_ACC, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 24'hffffff}, 1'b0, '{default: 0}},
    '{'{MODE_ACC, 1, -1, 1, 24'hffffff}, 1'b0, '{default: 0}},
    '{'{MODE_ACC, 32'sh123456, -32'sh654321, 32'sh0abcde, 24'd1000}, 1'b0, '{default: 0}},
    '{'{MODE_ADV, 0, 0, 0, 0}, 1'b0, '{default: 0}},
    '{'{MODE_LDV, -32'sh7fffffff, 32'sh7fffffff, 0, 24'hffffff}, 1'b0, '{default: 0}},
    '{'{MODE_ADV, 0, 0, 0, 0}, 1'b0, '{default: 0}}
  };

  initial begin
    in_item_t it;
    out_item_t got_state;
    g_const = 32'h10000;
    t_step = 32'h10000;
    m_own = 24'd1;
    for (int i = 0; i < 3; i++) begin
      body_vel[i] = 0;
      body_pos[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[n]) begin
      send_item(directed[n].it);
      got_state = pending_states[$];
      if (directed[n].typed && got_state !== directed[n].want)
        note_mismatch("directed row", directed[n].want, got_state);
    end
    drain();

    // Zero own mass, then extreme constants.
    write_reg(CFG_MASS, 32'd0);
    send_item('{MODE_ACC, 32'sh50000, 32'sh50000, 0, 24'd77});
    send_item('{MODE_ADV, 0, 0, 0, 0});
    drain();
    write_reg(CFG_MASS, 32'hffffff);
    write_reg(CFG_GRAV, 32'hffffffff);
    write_reg(CFG_STEP, 32'hffffffff);
    send_item('{MODE_LDV, 32'sh1000, -32'sh1000, 0, 0});
    send_item('{MODE_ACC, 32'sh30000, -32'sh20000, 32'sh10000, 24'hffffff});
    send_item('{MODE_ADV, 0, 0, 0, 0});
    drain();
    write_reg(CFG_STEP, 32'd0);
    send_item('{MODE_ADV, 0, 0, 0, 0});
    send_item('{MODE_ACC, 32'sh7fffffff, 0, 0, 24'hffffff});
    drain();
    write_reg(CFG_GRAV, 32'd0);
    write_reg(CFG_STEP, 32'h10000);
    send_item('{MODE_ACC, 32'sh10000, 0, 0, 24'hffffff});
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      write_reg(CFG_GRAV, phase == 4 ? 32'hffffffff : $urandom_range(0, 32'h40000));
      write_reg(CFG_STEP, phase == 3 ? 32'hffffffff : $urandom_range(0, 32'h20000));
      write_reg(CFG_MASS, $urandom_range(0, 9) == 0 ? 32'd0 : $urandom_range(1, 24'hffffff));
      if (phase == 2) fork
        begin
          hold_off = 1'b1;
          repeat (3000) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      for (int n = 0; n < 110; n++) begin
        it.mode = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) it.mode = MODE_ACC;
        it.vec_x = rand_coord(32'h100000);
        it.vec_y = rand_coord(32'h100000);
        it.vec_z = rand_coord(32'h100000);
        it.other_mass = ($urandom_range(0, 7) == 0) ? 24'(32'($urandom())) :
                        24'($urandom_range(0, 4000));
        if (it.mode == MODE_LDV && $urandom_range(0, 1))
          {it.vec_x, it.vec_y, it.vec_z} = {$signed($urandom_range(0, 32'h40000)) - 32'sh20000,
            $signed($urandom_range(0, 32'h40000)) - 32'sh20000,
            $signed($urandom_range(0, 32'h40000)) - 32'sh20000};
        send_item(it);
      end
      drain();
    end
    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
